// File: src/sliding_median_and_lowpass_core_assert.svh
// assertion macros for the sliding median and low-pass core
// no dependencies; included by files that carry concurrent assertions
`ifndef SLIDING_MEDIAN_AND_LOWPASS_CORE_ASSERT_SVH
`define SLIDING_MEDIAN_AND_LOWPASS_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SMLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SMLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/smlp_pkg.sv
// shared types and constants for the sliding median and low-pass core
// no dependencies
package smlp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int ACC_W    = 32;
    localparam int FRAC_W   = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_OLD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// File: src/smlp_sample_if.sv
// input sample channel: valid, ready and one signed sample
// depends on smlp_pkg
interface smlp_sample_if import smlp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: src/smlp_result_if.sv
// result channel: median, median flag and low-pass value
// depends on smlp_pkg
interface smlp_result_if import smlp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median_value;
    logic                       median_valid;
    logic signed [SAMPLE_W-1:0] smoothed_value;

    modport source (output valid, output median_value, output median_valid,
                    output smoothed_value, input ready);
    modport sink   (input valid, input median_value, input median_valid,
                    input smoothed_value, output ready);
endinterface

// File: src/smlp_cfg_if.sv
// configuration write channel carrying the low-pass gain
// depends on smlp_pkg
interface smlp_cfg_if import smlp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] smoothing_gain;

    modport source (output valid, output smoothing_gain, input ready);
    modport sink   (input valid, input smoothing_gain, output ready);
endinterface

// File: src/smlp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module smlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/sliding_median_and_lowpass_core.sv
// an accepted sample passes through S_OLD, S_SCAN and S_DONE before its result is registered
// a new sample is taken only in S_IDLE, after the rank scan
// that reads every window entry once through the single ram read port
// the result register lets the next sample in while a result waits
// reset: synchronous active low; window empty, accumulator zero, gain 6554
// depends on smlp_pkg, the three channel interfaces, smlp_ram and the assertion header
module sliding_median_and_lowpass_core import smlp_pkg::*; #(
    parameter int WINDOW = 15
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    smlp_sample_if.sink   i_sample,
    smlp_cfg_if.sink      i_cfg,
    smlp_result_if.source o_result
);

    `include "sliding_median_and_lowpass_core_assert.svh"

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int PROD_W = GAIN_W + 1 + ACC_W + 2;
    localparam logic [IDX_W-1:0] HALF     = IDX_W'(WINDOW / 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(WINDOW);

    // control state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_pend, n_pend;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [GAIN_W-1:0]  r_gain, n_gain;
    logic               r_out_valid, n_out_valid;

    // datapath registers
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic signed [SAMPLE_W-1:0] r_old, n_old;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic [IDX_W-1:0]   r_rs, n_rs;
    logic signed [SAMPLE_W-1:0] r_med, n_med;
    logic               r_med_hit, n_med_hit;
    logic [IDX_W-1:0]   r_rank [WINDOW];
    logic signed [SAMPLE_W-1:0] r_out_med, n_out_med;
    logic               r_out_mvalid, n_out_mvalid;
    logic signed [SAMPLE_W-1:0] r_out_smooth, n_out_smooth;

    // sequencer outputs
    logic               in_accept;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic               scan_step;
    logic               out_load;

    // rank unit signals
    logic signed [SAMPLE_W-1:0] v;
    logic               present, lt_old, lt_new;
    logic [IDX_W-1:0]   rank_upd;

    // low-pass signals
    logic signed [ACC_W+1:0]    d;
    logic signed [PROD_W-1:0]   p_round;
    logic signed [PROD_W-FRAC_W-1:0] inc;
    logic signed [PROD_W-FRAC_W:0]   acc_sum;
    logic signed [ACC_W:0]      y_round;
    logic signed [ACC_W-FRAC_W:0] y_full;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign in_accept      = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;

    smlp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_slot),
        .i_wr_data (r_x),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_OLD;
                end
            end
            S_OLD:  n_state = S_SCAN;
            S_SCAN: begin
                if (r_cnt == FULL) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ram_we      = 1'b0;
        ram_rd_addr = r_slot;
        scan_step   = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: ram_rd_addr = r_slot;
            S_OLD:  ram_we      = 1'b1;
            S_SCAN: begin
                ram_rd_addr = (r_cnt == FULL) ? '0 : r_cnt[IDX_W-1:0];
                scan_step   = 1'b1;
            end
            S_DONE: out_load = !r_out_valid || o_result.ready;
            default: ram_we = 1'b0;
        endcase
    end

    // rank unit: compare one stored entry against the outgoing and incoming keys,
    // keys ordered by value then by slot so that ties are broken consistently
    always_comb begin
        v       = $signed(ram_rd_data);
        present = ({1'b0, r_idx} < {1'b0, r_fill}) && (r_idx != r_slot);
        lt_old  = (r_old < v) || ((r_old == v) && (r_slot < r_idx));
        lt_new  = (r_x < v) || ((r_x == v) && (r_slot < r_idx));
        rank_upd = r_rank[r_idx]
                 - IDX_W'((r_fill == FULL) && lt_old)
                 + IDX_W'(lt_new);
    end

    // low-pass arithmetic
    always_comb begin
        d       = {{2{r_x[SAMPLE_W-1]}}, r_x, {FRAC_W{1'b0}}}
                - {{2{r_acc[ACC_W-1]}}, r_acc};
        p_round = r_prod + PROD_W'(32768);
        inc     = p_round[PROD_W-1:FRAC_W];
        acc_sum = {{(PROD_W-FRAC_W-ACC_W+1){r_acc[ACC_W-1]}}, r_acc}
                + {inc[PROD_W-FRAC_W-1], inc};
        y_round = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(32768);
        y_full  = y_round[ACC_W:FRAC_W];
        if (y_full > (ACC_W-FRAC_W+1)'(32767)) begin
            y_sat = 16'sh7fff;
        end else if (y_full < -(ACC_W-FRAC_W+1)'(32768)) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
    end

    // next values
    always_comb begin
        n_slot       = r_slot;
        n_fill       = r_fill;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_acc        = r_acc;
        n_gain       = r_gain;
        n_out_valid  = r_out_valid;
        n_idx        = r_idx;
        n_x          = r_x;
        n_old        = r_old;
        n_prod       = r_prod;
        n_rs         = r_rs;
        n_med        = r_med;
        n_med_hit    = r_med_hit;
        n_out_med    = r_out_med;
        n_out_mvalid = r_out_mvalid;
        n_out_smooth = r_out_smooth;

        if (i_cfg.valid) begin
            n_gain = i_cfg.smoothing_gain;
        end
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (in_accept) begin
            n_x = i_sample.sample;
        end

        // prefetched old entry, product, scan setup
        if (r_state == S_OLD) begin
            n_old     = $signed(ram_rd_data);
            n_prod    = $signed({1'b0, r_gain}) * d;
            n_cnt     = '0;
            n_pend    = 1'b0;
            n_rs      = '0;
            n_med_hit = 1'b0;
        end

        if (scan_step) begin
            // accumulator update once the product is ready
            if (r_cnt == '0) begin
                if (acc_sum > (PROD_W-FRAC_W+1)'(64'sd2147483647)) begin
                    n_acc = 32'sh7fffffff;
                end else if (acc_sum < -(PROD_W-FRAC_W+1)'(64'sd2147483648)) begin
                    n_acc = -32'sh80000000;
                end else begin
                    n_acc = acc_sum[ACC_W-1:0];
                end
            end
            // issue the next read address
            if (r_cnt != FULL) begin
                n_idx  = r_cnt[IDX_W-1:0];
                n_pend = 1'b1;
                n_cnt  = r_cnt + CNT_W'(1);
            end else begin
                n_pend = 1'b0;
            end
            // process the entry read last cycle
            if (r_pend && present) begin
                n_rs = r_rs + IDX_W'(!lt_new);
                if (rank_upd == HALF) begin
                    n_med     = v;
                    n_med_hit = 1'b1;
                end
            end
        end

        // result register and window bookkeeping
        if (out_load) begin
            n_fill       = (r_fill == FULL) ? FULL : r_fill + CNT_W'(1);
            n_slot       = (r_slot == LAST_IDX) ? '0 : r_slot + IDX_W'(1);
            n_out_valid  = 1'b1;
            n_out_mvalid = (n_fill == FULL);
            n_out_smooth = y_sat;
            if (n_fill != FULL) begin
                n_out_med = '0;
            end else if (r_rs == HALF) begin
                n_out_med = r_x;
            end else begin
                n_out_med = r_med;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_acc       <= '0;
            r_gain      <= GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_acc       <= n_acc;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_x          <= n_x;
        r_old        <= n_old;
        r_prod       <= n_prod;
        r_rs         <= n_rs;
        r_med        <= n_med;
        r_med_hit    <= n_med_hit;
        r_out_med    <= n_out_med;
        r_out_mvalid <= n_out_mvalid;
        r_out_smooth <= n_out_smooth;
        if (scan_step && r_pend && present) begin
            r_rank[r_idx] <= rank_upd;
        end
        if (out_load) begin
            r_rank[r_slot] <= r_rs;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.median_value   = r_out_med;
    assign o_result.median_valid   = r_out_mvalid;
    assign o_result.smoothed_value = r_out_smooth;

    // busy from the transaction on until the result is loaded
    `SMLP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !i_sample.ready,
        "input still ready right after a sample transaction")
    // a full window always holds exactly one entry at the median rank
    `SMLP_ASSERT_NOW(a_median_found, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_fill == FULL), r_med_hit || (r_rs == HALF),
        "no entry found at the median rank")
    // a flagged median needs a full window
    `SMLP_ASSERT_NOW(a_valid_needs_full, i_clk, i_rst_n,
        o_result.valid && o_result.median_valid, r_fill == FULL,
        "median flagged while window not full")
    // slot pointer and fill count stay in range
    `SMLP_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_slot} < {1'b0, LAST_IDX} + (IDX_W+1)'(1)) && (r_fill <= FULL),
        "window pointer or fill count out of range")

endmodule

// File: test/sliding_median_and_lowpass_core_test.sv
// testbench for sliding_median_and_lowpass_core: random sample traffic with a local predictor
// depends on smlp_pkg, the three channel interfaces and the core itself
`timescale 1ns / 100ps

module sliding_median_and_lowpass_core_test;
    import smlp_pkg::*;

    localparam int WINDOW     = 15;
    localparam int RUN_LIMIT  = 1_500_000;
    localparam int MAX_REPORT = 10;

    localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'hFFFF;
    localparam logic [GAIN_W-1:0] GAIN_ZERO = 16'h0000;
    localparam logic [GAIN_W-1:0] GAIN_MIN  = 16'h0001;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 16'h8000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median_value;
        logic                       median_valid;
        logic signed [SAMPLE_W-1:0] smoothed_value;
    } t_filter_result;

    logic i_clk;
    logic i_rst_n;

    smlp_sample_if s_bus ();
    smlp_cfg_if    c_bus ();
    smlp_result_if r_bus ();

    sliding_median_and_lowpass_core #(
        .WINDOW (WINDOW)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_bus),
        .i_cfg    (c_bus),
        .o_result (r_bus)
    );

    // samples waiting to be sent and results still owed by the core
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_filter_result             filter_results_due [$];

    // local copy of the filter state
    int                window_hist [WINDOW];
    int                hist_count = 0;
    int                hist_slot  = 0;
    int                lp_acc     = 0;
    logic [GAIN_W-1:0] lp_gain    = GAIN_RESET;

    int   mismatch_count   = 0;
    int   accepted_samples = 0;
    bit   sample_took      = 1'b0;
    bit   hold_off         = 1'b0;
    int   send_gap         = 0;
    int   recv_stall       = 0;
    bit   send_calm        = 1'b0;
    bit   recv_calm        = 1'b0;
    logic signed [SAMPLE_W-1:0] last_drawn = '0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // sample mix: extremes, values near zero, repeats, small steps and full range
    function automatic logic signed [SAMPLE_W-1:0] draw_sample(
        input logic signed [SAMPLE_W-1:0] prev
    );
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 64) - 32);
            3: return prev;
            4: return prev + SAMPLE_W'($urandom_range(0, 16) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // window median and low-pass update for one accepted sample
    task automatic advance_filter(input logic signed [SAMPLE_W-1:0] x);
        int             ranked [WINDOW];
        int             xi;
        int             key;
        int             i;
        int             j;
        longint         g;
        longint         d;
        longint         acc_next;
        longint         y;
        t_filter_result res;
        xi = x;
        window_hist[hist_slot] = xi;
        hist_slot = (hist_slot + 1 == WINDOW) ? 0 : hist_slot + 1;
        if (hist_count < WINDOW) begin
            hist_count++;
        end
        res.median_value = '0;
        res.median_valid = 1'b0;
        if (hist_count == WINDOW) begin
            ranked = window_hist;
            for (i = 1; i < WINDOW; i++) begin
                key = ranked[i];
                j = i - 1;
                while (j >= 0 && ranked[j] > key) begin
                    ranked[j + 1] = ranked[j];
                    j--;
                end
                ranked[j + 1] = key;
            end
            res.median_value = SAMPLE_W'(ranked[WINDOW / 2]);
            res.median_valid = 1'b1;
        end
        // acc += alpha * (x - acc), rounded half up, Q16.16
        g = lp_gain;
        d = longint'(xi) * 65536 - longint'(lp_acc);
        acc_next = longint'(lp_acc) + ((g * d + 32768) >>> 16);
        if (acc_next > 64'sd2147483647) begin
            acc_next = 64'sd2147483647;
        end
        if (acc_next < -64'sd2147483648) begin
            acc_next = -64'sd2147483648;
        end
        lp_acc = int'(acc_next);
        y = (acc_next + 32768) >>> 16;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        res.smoothed_value = y[SAMPLE_W-1:0];
        filter_results_due = {filter_results_due, res};
    endtask

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                   input logic [SAMPLE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // monitor: config and sample transactions feed the predictor, results are checked
    always @(posedge i_clk) begin
        t_filter_result want;
        sample_took = 1'b0;
        if (i_rst_n) begin
            if (c_bus.valid && c_bus.ready) begin
                lp_gain = c_bus.smoothing_gain;
            end
            if (s_bus.valid && s_bus.ready) begin
                sample_took = 1'b1;
                accepted_samples++;
                advance_filter(s_bus.sample);
            end
            if (r_bus.valid === 1'b1 && r_bus.ready) begin
                if (filter_results_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, r_bus.smoothed_value);
                end else begin
                    want = filter_results_due[0];
                    filter_results_due.delete(0);
                    if (r_bus.median_valid !== want.median_valid) begin
                        report_mismatch("median_valid", SAMPLE_W'(want.median_valid),
                                        SAMPLE_W'(r_bus.median_valid));
                    end
                    if (r_bus.median_value !== want.median_value) begin
                        report_mismatch("median_value", want.median_value, r_bus.median_value);
                    end
                    if (r_bus.smoothed_value !== want.smoothed_value) begin
                        report_mismatch("smoothed_value", want.smoothed_value,
                                        r_bus.smoothed_value);
                    end
                end
            end
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_bus.valid <= 1'b0;
        end else if (!s_bus.valid || sample_took) begin
            if (send_gap > 0) begin
                send_gap--;
                s_bus.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s_bus.valid  <= 1'b1;
                s_bus.sample <= pending_samples[0];
                pending_samples.delete(0);
                if ($urandom_range(0, 49) == 0) begin
                    send_calm = ~send_calm;
                end
                send_gap = pick_gap(send_calm);
            end else begin
                s_bus.valid <= 1'b0;
            end
        end
    end

    // result ready with random stalls, forced low during a hold-off
    always @(negedge i_clk) begin
        if ($urandom_range(0, 59) == 0) begin
            recv_calm = ~recv_calm;
        end
        if (hold_off) begin
            r_bus.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            r_bus.ready <= 1'b0;
        end else begin
            r_bus.ready <= 1'b1;
            recv_stall = pick_gap(recv_calm);
        end
    end

    // long receiver hold-offs while samples keep coming, so the core backs up
    initial begin
        while (accepted_samples < 300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (500) @(posedge i_clk);
        hold_off = 1'b0;
        while (accepted_samples < 1100) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // timeout
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic queue_random(input int n);
        repeat (n) begin
            last_drawn = draw_sample(last_drawn);
            pending_samples = {pending_samples, last_drawn};
        end
    endtask

    // block until every queued sample is sent and every result is back
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_bus.valid !== 1'b0
               || filter_results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        @(negedge i_clk);
        c_bus.valid          <= 1'b1;
        c_bus.smoothing_gain <= gain;
        @(posedge i_clk);
        while (!c_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        c_bus.valid <= 1'b0;
    endtask

    // reset, then stimulus phases separated by gain writes
    initial begin
        i_rst_n              = 1'b0;
        s_bus.valid          = 1'b0;
        s_bus.sample         = '0;
        c_bus.valid          = 1'b0;
        c_bus.smoothing_gain = '0;
        r_bus.ready          = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // window filling with extremes and bit patterns, then a full window
        pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
                            -16'sh5556, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                            16'sd100, -16'sd100, 16'sd256, -16'sd257, SAMPLE_MAX,
                            SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
        queue_random(180);
        wait_drained();

        write_gain(GAIN_MAX);
        queue_random(250);
        wait_drained();

        // zero gain freezes the low-pass output
        write_gain(GAIN_ZERO);
        queue_random(150);
        wait_drained();

        write_gain(GAIN_MIN);
        queue_random(200);
        wait_drained();

        write_gain(GAIN_HALF);
        queue_random(250);
        wait_drained();

        repeat (3) begin
            write_gain(GAIN_W'($urandom));
            queue_random(200);
            wait_drained();
        end

        repeat (4 * WINDOW) @(posedge i_clk);
        if (mismatch_count == 0 && filter_results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
